[rtl/core/assert_macros.svh]
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FBBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen at a clock edge outside reset
`define FBBA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[rtl/core/fbba_pkg.sv]
// types, constants and codes of the free block bitmap allocator
package fbba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 32;

  localparam int unsigned CNT_W      = 13;
  localparam int unsigned BLK_W      = 12;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ALLOC  = 1'd1;

  localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;
  localparam logic [BLK_W-1:0] FIRST_ALLOC_RST  = 12'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] total_blocks;
    logic [BLK_W-1:0] first_alloc;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0]  allocated_block;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

[rtl/core/fbba_intf.sv]
// request and response channel interfaces of the allocator
interface fbba_req_if import fbba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [BLK_W-1:0] block_number;

  modport source (output valid, output operation, output block_number, input ready);
  modport sink   (input valid, input operation, input block_number, output ready);
endinterface

interface fbba_rsp_if import fbba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BLK_W-1:0]  allocated_block;
  logic [STAT_W-1:0] status;

  modport source (output valid, output allocated_block, output status, input ready);
  modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

[rtl/core/fbba_map_ram.sv]
// bitmap word memory, one write port and one registered read port
module fbba_map_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fbba_ffs.sv]
// lowest set bit search over one bitmap word
module fbba_ffs #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0]         word_i,
  output logic                     found_o,
  output logic [$clog2(WIDTH)-1:0] pos_o
);

  localparam int unsigned OW = $clog2(WIDTH);

  always_comb begin
    pos_o   = '0;
    found_o = |word_i;
    for (int k = WIDTH - 1; k >= 0; k--) begin
      if (word_i[k]) begin
        pos_o = OW'(k);
      end
    end
  end

endmodule

[rtl/core/fbba_ctrl.sv]
// allocation sequencer: word/offset split, map scan and read-modify-write
`include "assert_macros.svh"

module fbba_ctrl import fbba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned OW        = $clog2(WORD_BITS);
  localparam int unsigned CAP       = (MAX_BLOCKS > (2 ** CNT_W) - 1) ?
                                      (2 ** CNT_W) - 1 : MAX_BLOCKS;
  localparam int unsigned RECIP     = (2 ** CNT_W) / WORD_BITS;

  localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAP);
  localparam logic [CNT_W-1:0] RECIP_C = CNT_W'(RECIP);
  localparam logic [CNT_W-1:0] WB_C    = CNT_W'(WORD_BITS);
  localparam logic [AW-1:0]    LAST_W  = AW'(MAP_WORDS - 1);

  state_e            state_q, state_d;
  logic              op_q, op_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  q0_q, q0_d;
  logic [AW-1:0]     word_q, word_d;
  logic [OW-1:0]     off_q, off_d;
  logic [CNT_W-1:0]  base_q, base_d;
  logic [AW-1:0]     clr_q, clr_d;
  res_t              res_q, res_d;

  logic [CNT_W-1:0]     count_eff;
  logic [2*CNT_W-1:0]   prod;
  logic [2*CNT_W-1:0]   qd;
  logic [CNT_W-1:0]     r0;
  logic                 fix_up;
  logic [CNT_W-1:0]     q_fix;
  logic [CNT_W-1:0]     r_fix;
  logic [CNT_W-1:0]     base_fix;
  logic [CNT_W:0]       lim;
  logic [CNT_W:0]       next_base;
  logic                 more;
  logic [WORD_BITS-1:0] cand;
  logic                 found;
  logic [OW-1:0]        pos;
  logic [CNT_W-1:0]     found_blk;
  logic [WORD_BITS-1:0] rdata;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;

  fbba_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  fbba_ffs #(
    .WIDTH (WORD_BITS)
  ) u_ffs (
    .word_i  (cand),
    .found_o (found),
    .pos_o   (pos)
  );

  // effective block count, clamped to the map size
  assign count_eff = (cfg_i.total_blocks > CAP_C) ? CAP_C : cfg_i.total_blocks;

  // word index by reciprocal, then one correction step
  assign prod     = n_q * RECIP_C;
  assign qd       = q0_q * WB_C;
  assign r0       = n_q - qd[CNT_W-1:0];
  assign fix_up   = (r0 >= WB_C);
  assign q_fix    = fix_up ? q0_q + CNT_W'(1) : q0_q;
  assign r_fix    = fix_up ? r0 - WB_C : r0;
  assign base_fix = fix_up ? qd[CNT_W-1:0] + WB_C : qd[CNT_W-1:0];

  // free candidates in the current word
  assign lim       = {1'b0, count_q} - {1'b0, base_q};
  assign next_base = {1'b0, base_q} + {1'b0, WB_C};
  assign more      = (next_base < {1'b0, count_q});
  assign found_blk = base_q + CNT_W'(pos);

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      cand[k] = rdata[k] && (OW'(k) >= off_q) && ((CNT_W + 1)'(k) < lim);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    n_q     <= n_d;
    count_q <= count_d;
    q0_q    <= q0_d;
    word_q  <= word_d;
    off_q   <= off_d;
    base_q  <= base_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    n_d         = n_q;
    count_d     = count_q;
    q0_d        = q0_q;
    word_d      = word_q;
    off_d       = off_q;
    base_d      = base_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = word_q;
    ram_wdata   = rdata;
    ram_re      = 1'b0;
    ram_raddr   = word_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '1;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_W) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = req_i.operation;
          count_d = count_eff;
          if (req_i.operation == OP_FREE) begin
            n_d = {1'b0, req_i.block_number};
            if ({1'b0, req_i.block_number} >= count_eff) begin
              res_d   = '{allocated_block: '0, status: STATUS_RANGE};
              state_d = ST_DONE;
            end else begin
              state_d = ST_DIV;
            end
          end else begin
            n_d = {1'b0, cfg_i.first_alloc};
            if ({1'b0, cfg_i.first_alloc} >= count_eff) begin
              res_d   = '{allocated_block: '0, status: STATUS_FULL};
              state_d = ST_DONE;
            end else begin
              state_d = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        q0_d    = prod[2*CNT_W-1:CNT_W];
        state_d = ST_FIX;
      end
      ST_FIX: begin
        word_d  = q_fix[AW-1:0];
        off_d   = r_fix[OW-1:0];
        base_d  = base_fix;
        state_d = ST_READ;
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (op_q == OP_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = rdata | (WORD_BITS'(1) << off_q);
          res_d     = '{allocated_block: '0, status: STATUS_OK};
          state_d   = ST_DONE;
        end else if (found) begin
          ram_we    = 1'b1;
          ram_wdata = rdata & ~(WORD_BITS'(1) << pos);
          res_d     = '{allocated_block: found_blk[BLK_W-1:0], status: STATUS_OK};
          state_d   = ST_DONE;
        end else if (more) begin
          ram_re    = 1'b1;
          ram_raddr = word_q + AW'(1);
          word_d    = word_q + AW'(1);
          base_d    = next_base[CNT_W-1:0];
          off_d     = '0;
        end else begin
          res_d   = '{allocated_block: '0, status: STATUS_FULL};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  `FBBA_ASSERT_NEVER(a_no_rw_overlap, ram_re && ram_we, "map read and write in one cycle")
  `FBBA_ASSERT(a_fix_in_word, (state_q == ST_FIX) |-> (r_fix < WB_C), "word offset out of range")
  `FBBA_ASSERT(a_read_in_map, ram_re |-> (ram_raddr <= LAST_W), "map read beyond last word")
  `FBBA_ASSERT(a_found_in_range, (state_q == ST_SCAN && op_q == OP_ALLOC && found) |-> (found_blk >= n_q && found_blk < count_q), "allocated block outside scan range")

endmodule

[rtl/core/free_block_bitmap_allocator.sv]
// top level of the first-fit free block bitmap allocator
//
//  channel  | dir | handshake      | payload
//  req_i    | in  | valid / ready  | operation, block_number
//  rsp_o    | out | valid / ready  | allocated_block, status
//  cfg      | in  | cfg_we_i       | cfg_idx_i, cfg_data_i
//
// a free in range passes the divide, fix, read and scan states before its result; an
// allocate scans the map one word at a time, up to MAX_BLOCKS/WORD_BITS words (128 at
// the defaults), through the one map read port; a free out of range or an allocate
// with an empty scan range goes straight to its result; after reset a clearing pass
// writes every map word free, with no request taken; config writes are taken throughout
// one item at a time; a result waits in the output register while the next beat is taken
`include "assert_macros.svh"

module free_block_bitmap_allocator import fbba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fbba_req_if.sink              req_i,
  fbba_rsp_if.source            rsp_o
);

  logic [CNT_W-1:0] total_blocks_q, total_blocks_d;
  logic [BLK_W-1:0] first_alloc_q, first_alloc_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  cfg_t cfg;
  req_t req;
  res_t res;
  logic res_valid;
  logic res_ready;
  logic in_ready;

  always_comb begin
    total_blocks_d = total_blocks_q;
    first_alloc_d  = first_alloc_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOTAL_BLOCKS: total_blocks_d = cfg_data_i[CNT_W-1:0];
        CFG_FIRST_ALLOC:  first_alloc_d  = cfg_data_i[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_blocks_q <= TOTAL_BLOCKS_RST;
      first_alloc_q  <= FIRST_ALLOC_RST;
      out_valid_q    <= 1'b0;
    end else begin
      total_blocks_q <= total_blocks_d;
      first_alloc_q  <= first_alloc_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign cfg = '{total_blocks: total_blocks_q, first_alloc: first_alloc_q};
  assign req = '{operation: req_i.operation, block_number: req_i.block_number};

  fbba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register, refilled as the pending beat leaves
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign req_i.ready           = in_ready;
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.allocated_block = out_q.allocated_block;
  assign rsp_o.status          = out_q.status;

  `FBBA_ASSERT(a_err_block_zero, (out_valid_q && out_q.status != STATUS_OK) |-> (out_q.allocated_block == '0), "failed request returned a block")
  `FBBA_ASSERT(a_status_code, out_valid_q |-> (out_q.status == STATUS_OK || out_q.status == STATUS_FULL || out_q.status == STATUS_RANGE), "reserved status code")
  `FBBA_ASSERT(a_one_at_a_time, (req_i.valid && in_ready) |=> !in_ready, "request taken while one in flight")

endmodule

[tb/free_block_bitmap_allocator_tb.sv]
// self-checking testbench of the first-fit free block bitmap allocator

class block_grant_checker;
  bit [fbba_pkg::MAX_BLOCKS_DEF-1:0] free_bits;
  logic [fbba_pkg::CNT_W-1:0]        total_blocks;
  logic [fbba_pkg::BLK_W-1:0]        first_alloc;
  fbba_pkg::res_t                    expected_grants[$];
  logic [fbba_pkg::BLK_W-1:0]        granted[$];
  int unsigned                       mismatches;

  function new();
    free_bits    = '1;
    total_blocks = fbba_pkg::TOTAL_BLOCKS_RST;
    first_alloc  = fbba_pkg::FIRST_ALLOC_RST;
    mismatches   = 0;
  endfunction

  function void set_register(logic [fbba_pkg::CFG_IDX_W-1:0] idx,
                             logic [fbba_pkg::CFG_DATA_W-1:0] data);
    if (idx == fbba_pkg::CFG_TOTAL_BLOCKS) begin
      total_blocks = data[fbba_pkg::CNT_W-1:0];
    end else begin
      first_alloc = data[fbba_pkg::BLK_W-1:0];
    end
  endfunction

  function int unsigned blk_count();
    return (total_blocks > fbba_pkg::MAX_BLOCKS_DEF) ? fbba_pkg::MAX_BLOCKS_DEF : total_blocks;
  endfunction

  function fbba_pkg::res_t predict_grant(fbba_pkg::req_t r);
    fbba_pkg::res_t res;
    int unsigned    lim;
    res.allocated_block = '0;
    res.status          = fbba_pkg::STATUS_OK;
    lim                 = blk_count();
    if (r.operation == fbba_pkg::OP_FREE) begin
      if (r.block_number >= lim) begin
        res.status = fbba_pkg::STATUS_RANGE;
      end else begin
        free_bits[r.block_number] = 1'b1;
      end
      return res;
    end
    for (int unsigned b = first_alloc; b < lim; b++) begin
      if (free_bits[b]) begin
        free_bits[b]        = 1'b0;
        res.allocated_block = fbba_pkg::BLK_W'(b);
        granted.push_back(res.allocated_block);
        return res;
      end
    end
    res.status = fbba_pkg::STATUS_FULL;
    return res;
  endfunction

  function void note_request(fbba_pkg::req_t r);
    expected_grants.push_back(predict_grant(r));
  endfunction

  function int unsigned pending();
    return expected_grants.size();
  endfunction

  task report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task check_result(fbba_pkg::res_t got);
    fbba_pkg::res_t want;
    if (expected_grants.size() == 0) begin
      report_mismatch($sformatf("beat with nothing pending, block %0d status %0d",
                                got.allocated_block, got.status));
      return;
    end
    want = expected_grants.pop_front();
    if (got.allocated_block !== want.allocated_block) begin
      report_mismatch($sformatf("allocated_block %0d, wanted %0d",
                                got.allocated_block, want.allocated_block));
    end
    if (got.status !== want.status) begin
      report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
    end
  endtask
endclass

module free_block_bitmap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbba_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int unsigned           cycles;

  fbba_req_if req_if ();
  fbba_rsp_if rsp_if ();

  block_grant_checker grants;

  free_block_bitmap_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic req_t make_req(logic op, logic [BLK_W-1:0] blk);
    req_t r;
    r.operation    = op;
    r.block_number = blk;
    return r;
  endfunction

  function automatic req_t pick_request();
    req_t        r;
    int unsigned lim;
    int unsigned sel;
    lim            = grants.blk_count();
    r.operation    = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
    r.block_number = BLK_W'($urandom());
    if (r.operation == OP_FREE) begin
      sel = $urandom_range(0, 99);
      if (sel < 60 && grants.granted.size() != 0) begin
        sel            = $urandom_range(0, grants.granted.size() - 1);
        r.block_number = grants.granted[sel];
        grants.granted.delete(sel);
      end else if (sel < 85 && lim != 0) begin
        r.block_number = BLK_W'($urandom_range(0, lim - 1));
      end
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    req_if.valid        <= 1'b1;
    req_if.operation    <= r.operation;
    req_if.block_number <= r.block_number;
    do @(posedge clk_i); while (!req_if.ready);
    grants.note_request(r);
  endtask

  task automatic apply_config(input logic [CNT_W-1:0] total, input logic [BLK_W-1:0] first);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TOTAL_BLOCKS;
    cfg_data_i <= CFG_DATA_W'(total);
    @(posedge clk_i);
    grants.set_register(CFG_TOTAL_BLOCKS, CFG_DATA_W'(total));
    cfg_idx_i  <= CFG_FIRST_ALLOC;
    cfg_data_i <= CFG_DATA_W'(first);
    @(posedge clk_i);
    grants.set_register(CFG_FIRST_ALLOC, CFG_DATA_W'(first));
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (grants.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned n);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    for (int unsigned k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          req_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      send_request(pick_request());
      burst_left--;
    end
  endtask

  // response side: stall pattern plus one long hold-off
  initial begin
    int unsigned stretch;
    int unsigned ready_pct;
    int unsigned hold_left;
    int unsigned results_seen;
    bit          held_off;
    res_t        got;
    stretch      = 0;
    ready_pct    = 100;
    hold_left    = 0;
    results_seen = 0;
    held_off     = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.allocated_block = rsp_if.allocated_block;
        got.status          = rsp_if.status;
        grants.check_result(got);
        results_seen++;
      end
      if (!held_off && results_seen >= 150 && req_if.valid) begin
        held_off  = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(4, 60);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 40;
            default: ready_pct = 10;
          endcase
        end
        stretch--;
        rsp_if.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned      random_items;
    int unsigned      n;
    logic [CNT_W-1:0] total;
    logic [BLK_W-1:0] first;
    grants              = new();
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_TOTAL_BLOCKS;
    cfg_data_i          <= '0;
    req_if.valid        <= 1'b0;
    req_if.operation    <= OP_ALLOC;
    req_if.block_number <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, double free, free below the scan start
    send_request(make_req(OP_ALLOC, 12'hfff));
    send_request(make_req(OP_ALLOC, 12'h000));
    send_request(make_req(OP_FREE, 12'd3));
    send_request(make_req(OP_FREE, 12'd3));
    send_request(make_req(OP_FREE, 12'd0));
    send_request(make_req(OP_FREE, 12'hfff));
    send_request(make_req(OP_ALLOC, 12'h555));
    wait_idle();
    // no blocks at all
    apply_config(13'd0, 12'd0);
    send_request(make_req(OP_ALLOC, 12'h000));
    send_request(make_req(OP_FREE, 12'd0));
    wait_idle();
    // count beyond the map, block zero handed out
    apply_config(13'h1fff, 12'd0);
    send_request(make_req(OP_ALLOC, 12'haaa));
    send_request(make_req(OP_ALLOC, 12'h000));
    send_request(make_req(OP_FREE, 12'hfff));
    send_request(make_req(OP_FREE, 12'd1));
    wait_idle();
    // scan start past the count, free out of range
    apply_config(13'd5, 12'hfff);
    send_request(make_req(OP_ALLOC, 12'h000));
    send_request(make_req(OP_FREE, 12'd5));
    send_request(make_req(OP_FREE, 12'd4));
    wait_idle();
    // last block only
    apply_config(13'd4096, 12'hfff);
    send_request(make_req(OP_ALLOC, 12'h000));
    send_request(make_req(OP_ALLOC, 12'h000));
    send_request(make_req(OP_FREE, 12'hfff));
    wait_idle();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: total = 13'd0;
        1: total = 13'd1;
        2, 3, 4, 5: total = CNT_W'($urandom_range(2, 96));
        6: total = 13'd4096;
        7: total = 13'h1fff;
        8: total = CNT_W'($urandom_range(4097, 8191));
        default: total = CNT_W'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 5))
        0: first = 12'd0;
        1: first = 12'hfff;
        2, 3, 4: first = BLK_W'($urandom_range(0, (total < 64) ? total : 64));
        default: first = BLK_W'($urandom());
      endcase
      apply_config(total, first);
      n = $urandom_range(20, 60);
      run_random_phase(n);
      random_items += n;
      wait_idle();
    end

    repeat (16) @(posedge clk_i);
    if (grants.mismatches == 0 && grants.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/fbba_pkg.sv
rtl/core/fbba_intf.sv
rtl/core/fbba_map_ram.sv
rtl/core/fbba_ffs.sv
rtl/core/fbba_ctrl.sv
rtl/core/free_block_bitmap_allocator.sv
tb/free_block_bitmap_allocator_tb.sv
